// File: sv/mqsb_pkg.sv
// ----------------------------------------------------------------------------
// mqsb_pkg
// Shared constants and types for the multi-queue shared buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package mqsb_pkg;

    localparam int ENTRIES_DEF    = 256;
    localparam int QUEUES_DEF     = 8;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_PEEK = 2'd2
    } action_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic alloc_en;
    } link_ctrl_t;

endpackage

`default_nettype wire

// File: sv/mqsb_link_store.sv
// ----------------------------------------------------------------------------
// mqsb_link_store
// Next-entry link memory with a fill count. Entries never handed out read
// as linking to the following entry, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module mqsb_link_store #(
    parameter int ENTRIES = mqsb_pkg::ENTRIES_DEF,
    localparam int LW = $clog2(ENTRIES + 1),
    localparam int AW = $clog2(ENTRIES)
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire mqsb_pkg::link_ctrl_t ctrl,
    input  wire logic [LW-1:0]        rd_addr,
    input  wire logic [LW-1:0]        wr_addr,
    input  wire logic [LW-1:0]        wr_link,
    output logic [LW-1:0]             rd_link
);

    localparam logic [LW-1:0] LINK_NULL = LW'(ENTRIES);
    localparam logic [LW-1:0] LAST      = LW'(ENTRIES - 1);

    logic [LW-1:0] link_mem [ENTRIES];
    logic [LW-1:0] mem_rd_reg;
    logic [LW-1:0] addr_rd_reg;
    logic [LW-1:0] fresh_reg;
    logic [LW-1:0] fresh_next;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            link_mem[AW'(wr_addr)] <= wr_link;
        end
        if (ctrl.rd_en) begin
            mem_rd_reg  <= link_mem[AW'(rd_addr)];
            addr_rd_reg <= rd_addr;
        end
    end

    always_comb begin
        fresh_next = fresh_reg;
        if (ctrl.alloc_en && (wr_addr == fresh_reg)) begin
            fresh_next = fresh_reg + LW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fresh_reg <= '0;
        end else begin
            fresh_reg <= fresh_next;
        end
    end

    // untouched entries read as the reset chain, taken from the fill count
    always_comb begin
        if (addr_rd_reg >= fresh_reg) begin
            rd_link = (addr_rd_reg == LAST) ? LINK_NULL : addr_rd_reg + LW'(1);
        end else begin
            rd_link = mem_rd_reg;
        end
    end

endmodule

`default_nettype wire

// File: sv/multi_queue_shared_buffer.sv
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer
// Several FIFO queues kept as linked lists in one shared entry store.
// ----------------------------------------------------------------------------
// Each item (push, pop, peek or reserved action on one queue) gives one
// result item with the success flag and the addressed queue's front word,
// empty flag and size afterwards. The block works on one item at a time:
// it reads the queue state (S_QRD), links the old tail for a push into a
// non-empty queue (S_LINK) or frees the head for a pop (S_POP), writes the
// queue state back and reads the front word (S_WB) and loads the result
// (S_FRONT); a queue number beyond QUEUES goes from S_QRD to S_FRONT.
// A result waits in an output register, so the next item is taken while
// it is still pending. No clearing pass runs after reset: links of entries
// never handed out come from a fill count.
`default_nettype none

module multi_queue_shared_buffer #(
    parameter int ENTRIES    = mqsb_pkg::ENTRIES_DEF,
    parameter int QUEUES     = mqsb_pkg::QUEUES_DEF,
    parameter int DATA_WIDTH = mqsb_pkg::DATA_WIDTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_action,
    input  wire logic [2:0]         s_queue_id,
    input  wire logic signed [31:0] s_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_accepted,
    output logic signed [31:0]      m_front_value,
    output logic                    m_queue_empty,
    output logic [8:0]              m_queue_size
);

    import mqsb_pkg::*;

    localparam int LW = $clog2(ENTRIES + 1);
    localparam int AW = $clog2(ENTRIES);
    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam logic [LW-1:0] LINK_NULL = LW'(ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_QRD,
        S_LINK,
        S_POP,
        S_WB,
        S_FRONT
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]            act_reg, act_next;
    logic [QW-1:0]         qidx_reg, qidx_next;
    logic                  qid_ok_reg, qid_ok_next;
    logic [31:0]           value_reg, value_next;
    logic                  ok_reg, ok_next;
    logic [LW-1:0]         cur_head_reg, cur_head_next;
    logic [LW-1:0]         cur_tail_reg, cur_tail_next;
    logic [LW-1:0]         cur_count_reg, cur_count_next;
    logic [LW-1:0]         lk_addr_reg, lk_addr_next;
    logic [LW-1:0]         lk_data_reg, lk_data_next;
    logic [LW-1:0]         free_head_reg, free_head_next;
    logic [QUEUES-1:0]     qvalid_reg, qvalid_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  acc_reg, acc_next;
    logic [31:0]           front_reg, front_next;
    logic                  empty_reg, empty_next;
    logic [8:0]            size_reg, size_next;

    // queue state and data memories
    logic [LW-1:0]         qhead_mem  [QUEUES];
    logic [LW-1:0]         qtail_mem  [QUEUES];
    logic [LW-1:0]         qcount_mem [QUEUES];
    logic [DATA_WIDTH-1:0] data_mem   [ENTRIES];

    logic [LW-1:0]         qh_rd_reg, qt_rd_reg, qc_rd_reg;
    logic                  qv_rd_reg;
    logic [DATA_WIDTH-1:0] data_rd_reg;

    logic                  q_rd_en, q_wr_en, d_rd_en, d_wr_en;
    logic [LW-1:0]         d_addr;

    link_ctrl_t            lk_ctrl;
    logic [LW-1:0]         lk_rd_addr, lk_wr_addr, lk_wr_link, lk_rd_link;

    logic [LW-1:0]         qh, qt, qc;

    mqsb_link_store #(
        .ENTRIES (ENTRIES)
    ) u_link (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (lk_ctrl),
        .rd_addr (lk_rd_addr),
        .wr_addr (lk_wr_addr),
        .wr_link (lk_wr_link),
        .rd_link (lk_rd_link)
    );

    always_ff @(posedge aclk) begin
        if (q_rd_en) begin
            qh_rd_reg <= qhead_mem[QW'(s_queue_id)];
            qt_rd_reg <= qtail_mem[QW'(s_queue_id)];
            qc_rd_reg <= qcount_mem[QW'(s_queue_id)];
            qv_rd_reg <= qvalid_reg[QW'(s_queue_id)];
        end
        if (q_wr_en) begin
            qhead_mem[qidx_reg]  <= cur_head_reg;
            qtail_mem[qidx_reg]  <= cur_tail_reg;
            qcount_mem[qidx_reg] <= cur_count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_wr_en) begin
            data_mem[AW'(d_addr)] <= DATA_WIDTH'(value_reg);
        end
        if (d_rd_en) begin
            data_rd_reg <= data_mem[AW'(d_addr)];
        end
    end

    // queues never written read as empty
    assign qh = qv_rd_reg ? qh_rd_reg : LINK_NULL;
    assign qt = qv_rd_reg ? qt_rd_reg : LINK_NULL;
    assign qc = qv_rd_reg ? qc_rd_reg : '0;

    always_comb begin
        state_next     = state_reg;
        act_next       = act_reg;
        qidx_next      = qidx_reg;
        qid_ok_next    = qid_ok_reg;
        value_next     = value_reg;
        ok_next        = ok_reg;
        cur_head_next  = cur_head_reg;
        cur_tail_next  = cur_tail_reg;
        cur_count_next = cur_count_reg;
        lk_addr_next   = lk_addr_reg;
        lk_data_next   = lk_data_reg;
        free_head_next = free_head_reg;
        qvalid_next    = qvalid_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        acc_next       = acc_reg;
        front_next     = front_reg;
        empty_next     = empty_reg;
        size_next      = size_reg;

        q_rd_en    = 1'b0;
        q_wr_en    = 1'b0;
        d_rd_en    = 1'b0;
        d_wr_en    = 1'b0;
        d_addr     = cur_head_reg;
        lk_ctrl    = '0;
        lk_rd_addr = free_head_reg;
        lk_wr_addr = free_head_reg;
        lk_wr_link = LINK_NULL;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    act_next    = s_action;
                    qidx_next   = QW'(s_queue_id);
                    qid_ok_next = (32'(s_queue_id) < 32'(QUEUES));
                    value_next  = s_value;
                    q_rd_en     = 1'b1;
                    lk_ctrl.rd_en = 1'b1;
                    state_next  = S_QRD;
                end
            end
            S_QRD: begin
                cur_head_next  = qh;
                cur_tail_next  = qt;
                cur_count_next = qc;
                state_next     = S_WB;
                if (!qid_ok_reg) begin
                    ok_next        = 1'b0;
                    cur_head_next  = LINK_NULL;
                    cur_count_next = '0;
                    state_next     = S_FRONT;
                end else begin
                    unique case (act_reg)
                        ACT_PUSH: begin
                            if (free_head_reg < LINK_NULL) begin
                                ok_next          = 1'b1;
                                d_wr_en          = 1'b1;
                                d_addr           = free_head_reg;
                                lk_ctrl.wr_en    = 1'b1;
                                lk_ctrl.alloc_en = 1'b1;
                                free_head_next   = lk_rd_link;
                                cur_tail_next    = free_head_reg;
                                cur_count_next   = qc + LW'(1);
                                if ((qh < LINK_NULL) && (qt < LINK_NULL)) begin
                                    lk_addr_next = qt;
                                    lk_data_next = free_head_reg;
                                    state_next   = S_LINK;
                                end else begin
                                    cur_head_next = free_head_reg;
                                end
                            end else begin
                                ok_next = 1'b0;
                            end
                        end
                        ACT_POP: begin
                            if (qh < LINK_NULL) begin
                                ok_next       = 1'b1;
                                lk_ctrl.rd_en = 1'b1;
                                lk_rd_addr    = qh;
                                state_next    = S_POP;
                            end else begin
                                ok_next = 1'b0;
                            end
                        end
                        ACT_PEEK: begin
                            ok_next = 1'b1;
                        end
                        default: begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            S_LINK: begin
                lk_ctrl.wr_en = 1'b1;
                lk_wr_addr    = lk_addr_reg;
                lk_wr_link    = lk_data_reg;
                state_next    = S_WB;
            end
            S_POP: begin
                cur_head_next = lk_rd_link;
                if (cur_head_reg == cur_tail_reg) begin
                    cur_tail_next = LINK_NULL;
                end
                if (cur_count_reg != '0) begin
                    cur_count_next = cur_count_reg - LW'(1);
                end
                lk_ctrl.wr_en  = 1'b1;
                lk_wr_addr     = cur_head_reg;
                lk_wr_link     = free_head_reg;
                free_head_next = cur_head_reg;
                state_next     = S_WB;
            end
            S_WB: begin
                q_wr_en               = 1'b1;
                qvalid_next[qidx_reg] = 1'b1;
                d_rd_en               = 1'b1;
                d_addr                = cur_head_reg;
                state_next            = S_FRONT;
            end
            S_FRONT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    acc_next     = ok_reg;
                    size_next    = 9'(cur_count_reg);
                    if ((cur_count_reg != '0) && (cur_head_reg < LINK_NULL)) begin
                        front_next = 32'(data_rd_reg);
                        empty_next = 1'b0;
                    end else begin
                        front_next = '0;
                        empty_next = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            qvalid_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            qvalid_reg    <= qvalid_next;
            m_valid_reg   <= m_valid_next;
        end
        act_reg       <= act_next;
        qidx_reg      <= qidx_next;
        qid_ok_reg    <= qid_ok_next;
        value_reg     <= value_next;
        ok_reg        <= ok_next;
        cur_head_reg  <= cur_head_next;
        cur_tail_reg  <= cur_tail_next;
        cur_count_reg <= cur_count_next;
        lk_addr_reg   <= lk_addr_next;
        lk_data_reg   <= lk_data_next;
        acc_reg       <= acc_next;
        front_reg     <= front_next;
        empty_reg     <= empty_next;
        size_reg      <= size_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_accepted    = acc_reg;
    assign m_front_value = front_reg;
    assign m_queue_empty = empty_reg;
    assign m_queue_size  = size_reg;

endmodule

`default_nettype wire

// File: dv/tb_multi_queue_shared_buffer.sv
// ----------------------------------------------------------------------------
// tb_multi_queue_shared_buffer
// Self-checking bench for the linked-list multi-queue shared buffer.
// ----------------------------------------------------------------------------
// A mirror of the queues, the free list and the entry store predicts the
// status item of every accepted push, pop, peek or reserved action. Status
// items are checked field by field in order. Stimulus is a short directed
// run, a fill of one queue up to the whole store with refused pushes, and
// push/pop mixes under several sender and receiver idle patterns. A long
// receiver hold-off adds back-pressure; a sender pause lets results drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_multi_queue_shared_buffer;
    import mqsb_pkg::*;

    localparam int         NUM_ENTRIES     = ENTRIES_DEF;
    localparam int         NUM_QUEUES      = QUEUES_DEF;
    localparam logic [8:0] NULL_PTR        = 9'(NUM_ENTRIES);
    localparam logic [1:0] ACT_RESERVED    = 2'd3;
    localparam int         CYCLE_LIMIT     = 400000;
    localparam int         HOLD_OFF_CYCLES = 300;
    localparam int         DRAIN_CYCLES    = 20;

    typedef struct packed {
        logic        accepted;
        logic [31:0] front_value;
        logic        queue_empty;
        logic [8:0]  queue_size;
    } queue_status_t;

    class linked_queue_mirror;
        logic [31:0]   word_mem [NUM_ENTRIES];
        logic [8:0]    next_ptr [NUM_ENTRIES];
        logic [8:0]    free_ptr;
        logic [8:0]    head_ptr [NUM_QUEUES];
        logic [8:0]    tail_ptr [NUM_QUEUES];
        logic [8:0]    depth    [NUM_QUEUES];
        int            used_entries;
        int            mismatches;
        queue_status_t status_due [$];

        function new();
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                word_mem[i] = '0;
                next_ptr[i] = 9'(i + 1);
            end
            next_ptr[NUM_ENTRIES-1] = NULL_PTR;
            free_ptr = '0;
            for (int q = 0; q < NUM_QUEUES; q++) begin
                head_ptr[q] = NULL_PTR;
                tail_ptr[q] = NULL_PTR;
                depth[q]    = '0;
            end
            used_entries = 0;
            mismatches   = 0;
        endfunction

        function int due_count();
            return status_due.size();
        endfunction

        function void take_op(logic [1:0] op, logic [2:0] qid, logic [31:0] word);
            queue_status_t st;
            logic [8:0]    slot;
            st = '0;
            case (op)
                ACT_PUSH: begin
                    slot = free_ptr;
                    if (slot != NULL_PTR) begin
                        free_ptr = next_ptr[slot];
                        if (head_ptr[qid] != NULL_PTR && tail_ptr[qid] != NULL_PTR) begin
                            next_ptr[tail_ptr[qid]] = slot;
                        end else begin
                            head_ptr[qid] = slot;
                        end
                        next_ptr[slot] = NULL_PTR;
                        tail_ptr[qid]  = slot;
                        word_mem[slot] = word;
                        depth[qid]     = depth[qid] + 9'd1;
                        used_entries++;
                        st.accepted = 1'b1;
                    end
                end
                ACT_POP: begin
                    slot = head_ptr[qid];
                    if (slot != NULL_PTR) begin
                        if (slot == tail_ptr[qid]) begin
                            tail_ptr[qid] = NULL_PTR;
                        end
                        head_ptr[qid]  = next_ptr[slot];
                        next_ptr[slot] = free_ptr;
                        free_ptr       = slot;
                        if (depth[qid] != 0) begin
                            depth[qid] = depth[qid] - 9'd1;
                        end
                        used_entries--;
                        st.accepted = 1'b1;
                    end
                end
                ACT_PEEK: begin
                    st.accepted = 1'b1;
                end
                default: begin
                    st.accepted = 1'b0;
                end
            endcase
            if (depth[qid] != 0 && head_ptr[qid] != NULL_PTR) begin
                st.front_value = word_mem[head_ptr[qid]];
                st.queue_empty = 1'b0;
            end else begin
                st.front_value = '0;
                st.queue_empty = 1'b1;
            end
            st.queue_size = depth[qid];
            status_due.push_back(st);
        endfunction

        function void check_status(logic ok, logic [31:0] front, logic empty, logic [8:0] size);
            queue_status_t want;
            if (status_due.size() == 0) begin
                $error("status item with no prediction pending");
                mismatches++;
                return;
            end
            want = status_due.pop_front();
            if (ok !== want.accepted) begin
                $error("accepted: expected %0d, got %0d", want.accepted, ok);
                mismatches++;
            end
            if (front !== want.front_value) begin
                $error("front_value: expected 0x%08h, got 0x%08h", want.front_value, front);
                mismatches++;
            end
            if (empty !== want.queue_empty) begin
                $error("queue_empty: expected %0d, got %0d", want.queue_empty, empty);
                mismatches++;
            end
            if (size !== want.queue_size) begin
                $error("queue_size: expected %0d, got %0d", want.queue_size, size);
                mismatches++;
            end
        endfunction
    endclass

    logic               aclk       = 1'b0;
    logic               aresetn    = 1'b0;
    logic               s_valid    = 1'b0;
    logic [1:0]         s_action   = ACT_PEEK;
    logic [2:0]         s_queue_id = '0;
    logic signed [31:0] s_value    = '0;
    logic               m_ready    = 1'b0;
    logic               s_ready;
    logic               m_valid;
    logic               m_accepted;
    logic signed [31:0] m_front_value;
    logic               m_queue_empty;
    logic [8:0]         m_queue_size;

    int src_idle_pct  = 8;
    int sink_idle_pct = 64;
    int rcv_hold      = 0;
    int cycle_count   = 0;

    linked_queue_mirror mirror;

    multi_queue_shared_buffer i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_queue_id    (s_queue_id),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_accepted    (m_accepted),
        .m_front_value (m_front_value),
        .m_queue_empty (m_queue_empty),
        .m_queue_size  (m_queue_size)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        forever begin
            @(negedge aclk);
            if (rcv_hold > 0) begin
                rcv_hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                mirror.check_status(m_accepted, m_front_value, m_queue_empty, m_queue_size);
            end
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_op(input logic [1:0] op, input logic [2:0] qid, input logic [31:0] word);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_action   <= op;
        s_queue_id <= qid;
        s_value    <= word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        mirror.take_op(op, qid, word);
    endtask

    task automatic run_mix(input int n, input int push_pct, input int pop_pct, input int peek_pct);
        int         roll;
        logic [1:0] op;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(99);
            if (roll < push_pct) begin
                op = ACT_PUSH;
            end else if (roll < push_pct + pop_pct) begin
                op = ACT_POP;
            end else if (roll < push_pct + pop_pct + peek_pct) begin
                op = ACT_PEEK;
            end else begin
                op = ACT_RESERVED;
            end
            send_op(op, 3'($urandom_range(NUM_QUEUES - 1)), pick_value());
        end
    endtask

    initial begin
        logic [2:0] fill_q;
        mirror = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty queue, reserved action, extremes of value and queue number
        send_op(ACT_PEEK,     3'd0, $urandom());
        send_op(ACT_POP,      3'd0, $urandom());
        send_op(ACT_RESERVED, 3'd7, 32'hFFFF_FFFF);
        send_op(ACT_PUSH,     3'd0, 32'h7FFF_FFFF);
        send_op(ACT_PUSH,     3'd0, 32'h8000_0000);
        send_op(ACT_PUSH,     3'd7, 32'hFFFF_FFFF);
        send_op(ACT_PUSH,     3'd7, 32'h0000_0000);
        send_op(ACT_PUSH,     3'd2, 32'h5555_5555);
        send_op(ACT_PUSH,     3'd5, 32'hAAAA_AAAA);
        send_op(ACT_PEEK,     3'd0, $urandom());
        send_op(ACT_RESERVED, 3'd0, 32'h1234_5678);
        send_op(ACT_POP,      3'd0, $urandom());
        send_op(ACT_PEEK,     3'd0, $urandom());
        send_op(ACT_POP,      3'd0, $urandom());
        send_op(ACT_POP,      3'd0, $urandom());
        send_op(ACT_POP,      3'd7, $urandom());
        send_op(ACT_PEEK,     3'd7, $urandom());
        send_op(ACT_POP,      3'd7, $urandom());
        send_op(ACT_POP,      3'd2, $urandom());
        send_op(ACT_PUSH,     3'd2, 32'h0000_0001);
        send_op(ACT_POP,      3'd5, $urandom());
        send_op(ACT_POP,      3'd2, $urandom());
        send_op(ACT_PEEK,     3'd5, $urandom());

        // one queue takes the whole store, then pushes get refused
        fill_q = 3'($urandom_range(NUM_QUEUES - 1));
        while (mirror.used_entries < NUM_ENTRIES) begin
            if ($urandom_range(9) == 0) begin
                run_mix(1, 0, 40, 40);
            end else begin
                send_op(ACT_PUSH, fill_q, pick_value());
            end
        end
        run_mix(10, 100, 0, 0);
        run_mix(80, 40, 40, 12);

        src_idle_pct  = 64;
        sink_idle_pct = 8;
        run_mix(100, 15, 70, 10);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (mirror.due_count() != 0) @(negedge aclk);
        run_mix(100, 30, 55, 10);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_mix(40, 45, 35, 12);
        rcv_hold = HOLD_OFF_CYCLES;
        run_mix(100, 40, 40, 12);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (mirror.due_count() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mirror.mismatches == 0 && mirror.due_count() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
